FILE: design/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

  // Code values used in the output stream.
  localparam logic [15:0] ReplChar    = 16'hFFFD;
  localparam logic [15:0] HighSurBase = 16'hD800;
  localparam logic [15:0] LowSurBase  = 16'hDC00;
  localparam logic [20:0] SuppBase    = 21'h10000;

  // Byte classes and continuation limits.
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [7:0] ContLow     = 8'h80;
  localparam logic [7:0] ContHigh    = 8'hBF;
  localparam logic [7:0] Lead2Min    = 8'hC2;
  localparam logic [7:0] Lead2Max    = 8'hDF;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead3Max    = 8'hEF;
  localparam logic [7:0] Lead3Surr   = 8'hED;
  localparam logic [7:0] Lead3MinLow = 8'hA0;
  localparam logic [7:0] Lead3SurrHi = 8'h9F;
  localparam logic [7:0] Lead4Min    = 8'hF0;
  localparam logic [7:0] Lead4Max    = 8'hF4;
  localparam logic [7:0] Lead4MinLow = 8'h90;
  localparam logic [7:0] Lead4MaxHi  = 8'h8F;
  localparam logic [5:0] ContMask    = 6'h3F;

  // Output queue geometry, in code units.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // Partial code point kept between bytes: 3 + 6 + 6 bits at most.
  localparam int unsigned PartialW = 15;

  // One UTF-16 result.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        error_seen;
    logic        last_of_run;
  } unit_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0] count;
    unit_t      unit0;
    unit_t      unit1;
  } unit_pair_t;

endpackage

FILE: design/u2u_decode.sv
// Sequence state and single-pass decode of one UTF-8 byte into up to two units.
module u2u_decode import u2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output unit_pair_t pair_o
);

  logic [PartialW-1:0] partial_point_q, partial_point_d;
  logic [1:0]          bytes_due_q, bytes_due_d;
  logic [7:0]          next_low_bound_q, next_low_bound_d;
  logic [7:0]          next_high_bound_q, next_high_bound_d;
  logic                sticky_error_q, sticky_error_d;

  logic                cont_ok;
  logic [20:0]         grown_point;
  logic [19:0]         surr_offset;
  logic [1:0]          due_left;
  logic [1:0]          cont_cnt;
  logic [15:0]         cont_code0, cont_code1;
  logic                cont_rep;
  logic                lead_emit;
  logic [15:0]         lead_code;
  logic                lead_rep;
  logic [1:0]          lead_due;
  logic [PartialW-1:0] lead_point;
  logic [7:0]          lead_lo, lead_hi;
  logic [1:0]          total_cnt;
  logic [15:0]         code_a, code_b;
  logic                rep_a, rep_b;
  logic                err_a;

  // Continuation byte: accept it into the partial point or flag it as bad.
  always_comb begin
    cont_ok     = (bytes_due_q != 2'd0) && (in_byte_i >= next_low_bound_q) &&
                  (in_byte_i <= next_high_bound_q);
    grown_point = {partial_point_q, in_byte_i[5:0] & ContMask};
    surr_offset = 20'(grown_point - SuppBase);
    due_left    = bytes_due_q - 2'd1;
    cont_cnt    = 2'd0;
    cont_code0  = ReplChar;
    cont_code1  = ReplChar;
    cont_rep    = 1'b0;
    if (bytes_due_q != 2'd0) begin
      if (cont_ok) begin
        if (due_left == 2'd0) begin
          if (grown_point[20:16] == 5'd0) begin
            cont_cnt   = 2'd1;
            cont_code0 = grown_point[15:0];
          end else begin
            cont_cnt   = 2'd2;
            cont_code0 = HighSurBase | {6'd0, surr_offset[19:10]};
            cont_code1 = LowSurBase | {6'd0, surr_offset[9:0]};
          end
        end else if (end_of_stream_i) begin
          cont_cnt = 2'd1;
          cont_rep = 1'b1;
        end
      end else begin
        cont_cnt = 2'd1;
        cont_rep = 1'b1;
      end
    end
  end

  // Lead byte: classify and set up the next sequence.
  always_comb begin
    lead_emit  = 1'b0;
    lead_code  = ReplChar;
    lead_rep   = 1'b0;
    lead_due   = 2'd0;
    lead_point = '0;
    lead_lo    = ContLow;
    lead_hi    = ContHigh;
    if (in_byte_i < AsciiLimit) begin
      lead_emit = 1'b1;
      lead_code = {8'd0, in_byte_i};
    end else if (in_byte_i >= Lead2Min && in_byte_i <= Lead2Max) begin
      lead_due   = 2'd1;
      lead_point = PartialW'(in_byte_i[4:0]);
    end else if (in_byte_i >= Lead3Min && in_byte_i <= Lead3Max) begin
      lead_due   = 2'd2;
      lead_point = PartialW'(in_byte_i[3:0]);
      if (in_byte_i == Lead3Min) begin
        lead_lo = Lead3MinLow;
      end
      if (in_byte_i == Lead3Surr) begin
        lead_hi = Lead3SurrHi;
      end
    end else if (in_byte_i >= Lead4Min && in_byte_i <= Lead4Max) begin
      lead_due   = 2'd3;
      lead_point = PartialW'(in_byte_i[2:0]);
      if (in_byte_i == Lead4Min) begin
        lead_lo = Lead4MinLow;
      end
      if (in_byte_i == Lead4Max) begin
        lead_hi = Lead4MaxHi;
      end
    end else begin
      lead_emit = 1'b1;
      lead_rep  = 1'b1;
    end
    // A sequence opened by the final byte is cut short.
    if (lead_due != 2'd0 && end_of_stream_i) begin
      lead_emit = 1'b1;
      lead_rep  = 1'b1;
    end
  end

  // Merge the two phases into result slots.
  always_comb begin
    code_a    = cont_code0;
    rep_a     = cont_rep;
    code_b    = cont_code1;
    rep_b     = 1'b0;
    total_cnt = cont_cnt;
    if (!cont_ok && lead_emit) begin
      total_cnt = cont_cnt + 2'd1;
      if (cont_cnt == 2'd0) begin
        code_a = lead_code;
        rep_a  = lead_rep;
      end else begin
        code_b = lead_code;
        rep_b  = lead_rep;
      end
    end
    if (total_cnt == 2'd0) begin
      rep_a = 1'b0;
    end
    err_a                     = sticky_error_q | rep_a;
    pair_o.count              = total_cnt;
    pair_o.unit0.code_unit    = code_a;
    pair_o.unit0.replaced     = rep_a;
    pair_o.unit0.error_seen   = err_a;
    pair_o.unit0.last_of_run  = (total_cnt == 2'd1);
    pair_o.unit1.code_unit    = code_b;
    pair_o.unit1.replaced     = rep_b;
    pair_o.unit1.error_seen   = err_a | rep_b;
    pair_o.unit1.last_of_run  = (total_cnt == 2'd2);
  end

  // Next sequence state.
  always_comb begin
    if (end_of_stream_i) begin
      partial_point_d   = '0;
      bytes_due_d       = 2'd0;
      next_low_bound_d  = ContLow;
      next_high_bound_d = ContHigh;
      sticky_error_d    = 1'b0;
    end else begin
      sticky_error_d = sticky_error_q | rep_a | rep_b;
      if (cont_ok) begin
        partial_point_d   = (due_left == 2'd0) ? '0 : grown_point[PartialW-1:0];
        bytes_due_d       = due_left;
        next_low_bound_d  = ContLow;
        next_high_bound_d = ContHigh;
      end else begin
        partial_point_d   = lead_point;
        bytes_due_d       = lead_due;
        next_low_bound_d  = lead_lo;
        next_high_bound_d = lead_hi;
      end
    end
  end

  // State registers, updated once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_point_q   <= '0;
      bytes_due_q       <= 2'd0;
      next_low_bound_q  <= ContLow;
      next_high_bound_q <= ContHigh;
      sticky_error_q    <= 1'b0;
    end else if (accept_i) begin
      partial_point_q   <= partial_point_d;
      bytes_due_q       <= bytes_due_d;
      next_low_bound_q  <= next_low_bound_d;
      next_high_bound_q <= next_high_bound_d;
      sticky_error_q    <= sticky_error_d;
    end
  end

  // No partial point is held outside an open sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_due_q == 2'd0) |-> (partial_point_q == '0))
    else $error("partial point held with no sequence open");

  // The allowed continuation window is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_low_bound_q <= next_high_bound_q)
    else $error("empty continuation window");

  // An accepted final byte leaves the decoder in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_stream_i) |=> (bytes_due_q == 2'd0 && !sticky_error_q))
    else $error("state not cleared after end of stream");

endmodule

FILE: design/u2u_unit_fifo.sv
// Small output queue of code units; takes up to two units per cycle, gives one.
module u2u_unit_fifo import u2u_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  unit_pair_t pair_i,
  output logic       has_room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output unit_t      unit_o
);

  unit_t                entries_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]  count_q, count_d;
  logic [FifoCntW-1:0]  push_n, pop_n;
  logic [FifoPtrW-1:0]  wr_ptr_next;

  // Room for a full pair of units is needed before taking a request.
  assign has_room_o  = (count_q <= FifoCntW'(FifoDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign unit_o      = entries_q[rd_ptr_q];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    push_n      = push_i ? {{(FifoCntW - 2){1'b0}}, pair_i.count} : '0;
    pop_n       = (out_valid_o && out_ready_i) ? FifoCntW'(1) : '0;
    wr_ptr_next = wr_ptr_q + FifoPtrW'(1);
    wr_ptr_d    = wr_ptr_q + push_n[FifoPtrW-1:0];
    rd_ptr_d    = rd_ptr_q + pop_n[FifoPtrW-1:0];
    count_d     = count_q + push_n - pop_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Unit storage; the second unit of a pair lands in the following slot.
  always_ff @(posedge clk_i) begin
    if (push_i && pair_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= pair_i.unit0;
    end
    if (push_i && pair_i.count == 2'd2) begin
      entries_q[wr_ptr_next] <= pair_i.unit1;
    end
  end

  // Occupancy never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("output queue overflow");

  // Occupancy follows pushes and pops exactly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      (count_q == FifoCntW'($past(count_q) + $past(push_n) - $past(pop_n))))
    else $error("output queue count drift");

  // Pointer distance matches the occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != FifoCntW'(FifoDepth)) |->
      (FifoPtrW'(wr_ptr_q - rd_ptr_q) == count_q[FifoPtrW-1:0]))
    else $error("output queue pointers disagree with count");

endmodule

FILE: design/utf8_to_utf16_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 decoder with replacement characters.
//
// Input channel: one UTF-8 byte per request (in_byte_i, end_of_stream_i),
// taken at a clock edge where in_valid_i and in_ready_o are both high.
// Output channel: one UTF-16 code unit per request (code_unit_o with the
// replaced_o, error_seen_o and last_of_run_o flags), taken where
// out_valid_o and out_ready_i are both high.
// A byte is decoded in the cycle it is accepted; with an empty queue its
// units are visible on the output in the following cycle. A byte causes
// zero, one or two units; the second follows once the first is taken.
// Throughput is one byte per cycle while bytes give at most one unit each
// and the receiver does not stall; the single-unit output port sets the
// limit when surrogate pairs or a bad byte followed by a replacement appear.
// A four-unit output queue sits between the decoder and the output port, so
// bytes keep being accepted while a unit waits; in_ready_o drops only when
// fewer than two slots are free, which happens when the receiver stalls or
// when two-unit bytes arrive faster than the output drains them.
// Reset clears the sequence state, the sticky error flag and the queue.
// After a byte marked end_of_stream_i, the decoder returns to that state.
module utf8_to_utf16_decoder_unit import u2u_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        replaced_o,
  output logic        error_seen_o,
  output logic        last_of_run_o
);

  logic       accept;
  unit_pair_t pair;
  unit_t      head_unit;

  // A byte request completes when the queue has room for a full pair.
  assign accept = in_valid_i && in_ready_o;

  u2u_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .pair_o          (pair)
  );

  u2u_unit_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .pair_i      (pair),
    .has_room_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .unit_o      (head_unit)
  );

  // Output fields from the head of the queue.
  assign code_unit_o   = head_unit.code_unit;
  assign replaced_o    = head_unit.replaced;
  assign error_seen_o  = head_unit.error_seen;
  assign last_of_run_o = head_unit.last_of_run;

endmodule

FILE: tb/utf8_to_utf16_decoder_unit_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 decoder unit.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit_tb import u2u_pkg::*;;

  // Directed rows are either checked against a value typed into the table,
  // or against the decoder model below.
  typedef enum logic {
    ByModel,
    ByValue
  } chk_e;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        eos;
    chk_e        how;
    logic [15:0] code_unit;
    logic        replaced;
    logic        error_seen;
  } stim_row_t;

  localparam int unsigned NumDirected = 26;
  localparam int unsigned NumRandom   = 950;
  localparam int unsigned IdlePct     = 14;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned MaxReports  = 10;

  // Extremes, every byte class, and each malformed case.
  localparam stim_row_t DirTable [NumDirected] = '{
    '{8'h00, 1'b0, ByValue, 16'h0000, 1'b0, 1'b0},  // lowest ASCII
    '{8'h7F, 1'b0, ByValue, 16'h007F, 1'b0, 1'b0},  // highest ASCII
    '{8'h80, 1'b0, ByValue, ReplChar, 1'b1, 1'b1},  // stray continuation
    '{8'hFF, 1'b1, ByValue, ReplChar, 1'b1, 1'b1},  // invalid lead, then end
    '{8'hC2, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // lowest two-byte point
    '{8'h80, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hE0, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // lowest three-byte point
    '{8'hA0, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hED, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // surrogate range: bad
    '{8'hA0, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // continuation, then bad lead
    '{8'hF0, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // lowest four-byte point
    '{8'h90, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hF4, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // highest code point
    '{8'h8F, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hF4, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // above U+10FFFF
    '{8'h90, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},
    '{8'hE1, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // cut short by the end
    '{8'h80, 1'b1, ByValue, ReplChar, 1'b1, 1'b1},
    '{8'hC3, 1'b1, ByValue, ReplChar, 1'b1, 1'b1},  // lead as last byte
    '{8'hE2, 1'b0, ByModel, 16'h0, 1'b0, 1'b0},     // ASCII breaks a sequence
    '{8'h41, 1'b1, ByModel, 16'h0, 1'b0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        end_of_stream_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] code_unit_o;
  logic        replaced_o;
  logic        error_seen_o;
  logic        last_of_run_o;

  // Decoder state as predicted by the testbench.
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic [7:0]  cont_lo;
  logic [7:0]  cont_hi;
  logic        sticky_err;

  unit_t       expected_units[$];
  logic [7:0]  seq_bytes[$];
  int unsigned failures;
  int unsigned cycles = 0;
  logic        steady;

  utf8_to_utf16_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_unit_o    (code_unit_o),
    .replaced_o     (replaced_o),
    .error_seen_o   (error_seen_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** utf8_to_utf16_decoder_unit: FAILED **");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("%s", msg);
  endtask

  // Appends one code unit; a replacement sets the sticky flag first.
  function automatic void add_unit(inout unit_t [1:0] res, inout int n,
                                   input logic [15:0] cu, input logic rep);
    if (n < 2) begin
      if (rep) sticky_err = 1'b1;
      res[n] = '{code_unit: cu, replaced: rep, error_seen: sticky_err, last_of_run: 1'b0};
      n++;
    end
  endfunction

  function automatic void drop_sequence();
    cp_acc    = '0;
    cont_left = '0;
    cont_lo   = ContLow;
    cont_hi   = ContHigh;
  endfunction

  // Decodes one byte against the predicted state and returns its units.
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic eos,
                                           output unit_t [1:0] res, output int n);
    logic        as_lead;
    logic [19:0] offs;
    res     = '0;
    n       = 0;
    as_lead = 1'b1;
    if (cont_left != 0) begin
      if (b >= cont_lo && b <= cont_hi) begin
        as_lead   = 1'b0;
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        cont_lo   = ContLow;
        cont_hi   = ContHigh;
        if (cont_left == 0) begin
          // Complete point: one unit or a surrogate pair.
          if (cp_acc <= 21'h00FFFF) begin
            add_unit(res, n, cp_acc[15:0], 1'b0);
          end else begin
            offs = 20'(cp_acc - SuppBase);
            add_unit(res, n, HighSurBase | {6'd0, offs[19:10]}, 1'b0);
            add_unit(res, n, LowSurBase | {6'd0, offs[9:0]}, 1'b0);
          end
          cp_acc = '0;
        end else if (eos) begin
          add_unit(res, n, ReplChar, 1'b1);
        end
      end else begin
        // Bad continuation: replace, then take the byte as a new lead.
        add_unit(res, n, ReplChar, 1'b1);
        drop_sequence();
      end
    end
    if (as_lead) begin
      if (b < AsciiLimit) begin
        add_unit(res, n, {8'd0, b}, 1'b0);
      end else if (b >= Lead2Min && b <= Lead2Max) begin
        cp_acc    = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b >= Lead3Min && b <= Lead3Max) begin
        cp_acc    = {17'd0, b[3:0]};
        cont_left = 2'd2;
        if (b == Lead3Min) cont_lo = Lead3MinLow;
        if (b == Lead3Surr) cont_hi = Lead3SurrHi;
      end else if (b >= Lead4Min && b <= Lead4Max) begin
        cp_acc    = {18'd0, b[2:0]};
        cont_left = 2'd3;
        if (b == Lead4Min) cont_lo = Lead4MinLow;
        if (b == Lead4Max) cont_hi = Lead4MaxHi;
      end else begin
        add_unit(res, n, ReplChar, 1'b1);
      end
      if (cont_left != 0 && eos) add_unit(res, n, ReplChar, 1'b1);
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    // The end of a stream returns everything to its reset state.
    if (eos) begin
      drop_sequence();
      sticky_err = 1'b0;
    end
  endfunction

  // Sends one request; its expected units are queued as it is driven.
  task automatic send_byte(input stim_row_t row);
    unit_t [1:0] res;
    int          n;
    unit_t       typed;
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= row.in_byte;
    end_of_stream_i <= row.eos;
    decode_utf8_byte(row.in_byte, row.eos, res, n);
    if (row.how == ByValue) begin
      typed = '{code_unit: row.code_unit, replaced: row.replaced,
                error_seen: row.error_seen, last_of_run: 1'b1};
      expected_units.push_back(typed);
    end else begin
      for (int i = 0; i < n; i++) expected_units.push_back(res[i]);
    end
    // Ready is stable mid-cycle; the request is taken at the next edge.
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Holds the sender off until every expected unit has come out.
  task automatic drain_units();
    in_valid_i <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
  endtask

  // Builds the UTF-8 bytes of one code point.
  function automatic void encode_point(input logic [20:0] cp);
    seq_bytes.delete();
    if (cp < 21'h80) begin
      seq_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      seq_bytes.push_back({3'b110, cp[10:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      seq_bytes.push_back({4'b1110, cp[15:12]});
      seq_bytes.push_back({2'b10, cp[11:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      seq_bytes.push_back({5'b11110, cp[20:18]});
      seq_bytes.push_back({2'b10, cp[17:12]});
      seq_bytes.push_back({2'b10, cp[11:6]});
      seq_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Picks a legal code point, often next to the range limits of its lead.
  function automatic logic [20:0] pick_point(input int unsigned len);
    logic [20:0] cp;
    int unsigned edge_pick;
    edge_pick = $urandom_range(9);
    case (len)
      1: cp = 21'($urandom_range(8'h7F));
      2: cp = 21'($urandom_range(16'h7FF, 16'h80));
      3: begin
        if (edge_pick == 0) cp = 21'($urandom_range(16'hFFF, 16'h800));
        else if (edge_pick == 1) cp = 21'($urandom_range(16'hD7FF, 16'hD000));
        else begin
          do cp = 21'($urandom_range(16'hFFFF, 16'h800));
          while (cp >= 21'hD800 && cp <= 21'hDFFF);
        end
      end
      default: begin
        if (edge_pick == 0) cp = 21'($urandom_range(21'h3FFFF, 21'h10000));
        else if (edge_pick == 1) cp = 21'($urandom_range(21'h10FFFF, 21'h100000));
        else cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      end
    endcase
    return cp;
  endfunction

  // Receiver: random stalls, results sampled mid-cycle and checked.
  initial begin
    unit_t exp_unit;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_units.size() == 0) begin
          note_failure($sformatf("unexpected unit %04h rep %0d err %0d last %0d",
                                 code_unit_o, replaced_o, error_seen_o, last_of_run_o));
        end else begin
          exp_unit = expected_units.pop_front();
          if (code_unit_o !== exp_unit.code_unit || replaced_o !== exp_unit.replaced ||
              error_seen_o !== exp_unit.error_seen ||
              last_of_run_o !== exp_unit.last_of_run) begin
            note_failure($sformatf(
              "mismatch: got %04h rep %0d err %0d last %0d, expected %04h %0d %0d %0d",
              code_unit_o, replaced_o, error_seen_o, last_of_run_o,
              exp_unit.code_unit, exp_unit.replaced, exp_unit.error_seen,
              exp_unit.last_of_run));
          end
        end
      end
      @(posedge clk_i);
    end
  end

  // Sender: reset, directed table, random streams, then the final verdict.
  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    logic        eos;
    stim_row_t   row;

    failures        = 0;
    steady          = 1'b0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    in_byte_i       <= '0;
    end_of_stream_i <= 1'b0;
    cp_acc          = '0;
    cont_left       = '0;
    cont_lo         = ContLow;
    cont_hi         = ContHigh;
    sticky_err      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    for (int i = 0; i < NumDirected; i++) send_byte(DirTable[i]);
    drain_units();

    // Random part: mostly well-formed sequences, some noise and breakage.
    sent = 0;
    while (sent < NumRandom) begin
      steady = (sent >= 400 && sent < 600);
      if (sent >= 700 && sent < 705) drain_units();
      kind = $urandom_range(99);
      if (kind < 82) begin
        len = (kind < 20) ? 1 : (kind < 40) ? 2 : (kind < 60) ? 3 : 4;
        encode_point(pick_point(len));
      end else if (kind < 88) begin
        seq_bytes.delete();
        seq_bytes.push_back(8'($urandom_range(255)));
      end else begin
        encode_point(pick_point($urandom_range(4, 2)));
        if (kind < 95) begin
          // Cut the sequence short; the next lead breaks it.
          repeat ($urandom_range(seq_bytes.size() - 1, 1)) void'(seq_bytes.pop_back());
        end else begin
          // Corrupt one continuation byte.
          pos = $urandom_range(seq_bytes.size() - 1, 1);
          seq_bytes[pos] = 8'($urandom_range(255));
        end
      end
      eos = ($urandom_range(11) == 0);
      for (int i = 0; i < seq_bytes.size(); i++) begin
        row = '{seq_bytes[i], (i == seq_bytes.size() - 1) && eos, ByModel,
                16'h0, 1'b0, 1'b0};
        send_byte(row);
        sent++;
      end
    end
    steady = 1'b0;

    // Wait for the last units, then let the bench idle so that strays show.
    drain_units();
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_units.size() != 0) begin
      note_failure($sformatf("%0d expected units never arrived", expected_units.size()));
    end
    if (failures == 0) begin
      $display("** utf8_to_utf16_decoder_unit: PASSED **");
    end else begin
      $display("** utf8_to_utf16_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
